// ===== design/sktab_pkg.sv =====
// Shared constants and codes for the sorted key table.
package sktab_pkg;

    localparam int TABLE_DEPTH = 32;
    localparam int KEY_CHARS   = 8;

    localparam int IDX_W   = $clog2(TABLE_DEPTH);
    localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
    localparam int KEY_W   = 64;
    localparam int DATA_W  = 56;
    localparam int ENTRY_W = KEY_W + DATA_W;

    localparam int S_TDATA_W = 128;
    localparam int M_TDATA_W = 64;

    // Keep only the top KEY_CHARS bytes of a key.
    localparam logic [KEY_W-1:0] KEY_MASK = {KEY_W{1'b1}} << (8 * (8 - KEY_CHARS));

    localparam logic [1:0] CMD_LOOKUP = 2'd0;
    localparam logic [1:0] CMD_INSERT = 2'd1;
    localparam logic [1:0] CMD_DELETE = 2'd2;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

endpackage

// ===== design/sktab_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module sktab_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/sorted_key_table_top.sv =====
// Sorted key table: lookup, insert and delete over a RAM-held ordered array.
//
// Usage:
//   One command enters on the s_ stream (lookup, insert or delete with a key
//   and four data words) and exactly one result leaves on the m_ stream.
//   The block works on one command at a time; s_tready is high only while
//   the sequencer is idle.
//   Sequence: each probe of the binary search over n entries is a RAM read
//   then a compare, and a closing step ends the search. Lookup and delete
//   then re-read the found slot. Insert and delete move the entries behind
//   the slot, one read and one write per entry moved, then insert writes
//   the new entry and raises the count, or delete drops the count. Then the
//   result register is loaded once it is free; a full-table insert or an
//   unused command code goes straight there.
//   The result sits in an output register; a new command can be taken while
//   it waits, but the next result is held back until m_tready takes it.
//   Reset empties the table at once (the count goes to zero); RAM contents
//   are not cleared, since only slots below the count are ever used.
module sorted_key_table_top
    import sktab_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // command[1:0], key[65:2], op_value[81:66], op_modifier[97:82],
    // op_format[105:98], cpu_flags[121:106], zero fill[127:122]
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // status[1:0], found_value[17:2], found_modifier[33:18],
    // found_format[41:34], found_cpu_flags[57:42], entry_count[63:58]
    output logic [M_TDATA_W-1:0] m_tdata
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_CHK_RD,
        S_CHK_CMP,
        S_INS_RD,
        S_INS_WR,
        S_DEL_RD,
        S_DEL_WR,
        S_DONE
    } t_state;

    localparam int SUM_W = CNT_W + 1;

    t_state             r_state;
    logic [1:0]         r_cmd;
    logic [KEY_W-1:0]   r_key;
    logic [DATA_W-1:0]  r_data;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   r_lo;
    logic [CNT_W-1:0]   r_hi;
    logic [CNT_W-1:0]   r_mid;
    logic [CNT_W-1:0]   r_i;
    logic [1:0]         r_status;
    logic [DATA_W-1:0]  r_found;
    logic               r_out_valid;
    logic [M_TDATA_W-1:0] r_out_data;

    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [IDX_W-1:0]   ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;

    logic [SUM_W-1:0]   w_sum;
    logic [CNT_W-1:0]   w_mid;
    logic [CNT_W-1:0]   w_i_dec;
    logic [CNT_W-1:0]   w_i_inc;
    logic [KEY_W-1:0]   w_rd_key;
    logic               w_key_lt;
    logic               w_key_eq;
    logic               w_go_right;
    logic               w_accept;
    logic               w_out_free;

    logic [1:0]         w_in_cmd;
    logic [KEY_W-1:0]   w_in_key;
    logic [DATA_W-1:0]  w_in_data;

    sktab_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign w_in_cmd  = s_tdata[1:0];
    assign w_in_key  = s_tdata[65:2] & KEY_MASK;
    assign w_in_data = {s_tdata[81:66], s_tdata[97:82], s_tdata[105:98], s_tdata[121:106]};

    assign s_tready   = (r_state == S_IDLE);
    assign w_accept   = s_tvalid && s_tready;
    assign w_out_free = !r_out_valid || m_tready;

    assign w_sum   = {1'b0, r_lo} + {1'b0, r_hi};
    assign w_mid   = w_sum[SUM_W-1:1];
    assign w_i_dec = r_i - CNT_W'(1);
    assign w_i_inc = r_i + CNT_W'(1);

    // Shared key comparator: stored key against command key.
    assign w_rd_key   = ram_rdata[ENTRY_W-1:DATA_W];
    assign w_key_lt   = w_rd_key < r_key;
    assign w_key_eq   = w_rd_key == r_key;
    // Insert searches for the upper bound, lookup and delete for the lower bound.
    assign w_go_right = (r_cmd == CMD_INSERT) ? (w_key_lt || w_key_eq) : w_key_lt;

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = ram_rdata;
        ram_raddr = '0;
        unique case (r_state)
            S_SRCH_RD: ram_raddr = w_mid[IDX_W-1:0];
            S_CHK_RD:  ram_raddr = r_lo[IDX_W-1:0];
            S_INS_RD: begin
                if (r_i > r_lo) begin
                    ram_raddr = w_i_dec[IDX_W-1:0];
                end else begin
                    ram_we    = 1'b1;
                    ram_waddr = r_lo[IDX_W-1:0];
                    ram_wdata = {r_key, r_data};
                end
            end
            S_INS_WR: begin
                ram_we    = 1'b1;
                ram_waddr = r_i[IDX_W-1:0];
            end
            S_DEL_RD:  ram_raddr = w_i_inc[IDX_W-1:0];
            S_DEL_WR: begin
                ram_we    = 1'b1;
                ram_waddr = r_i[IDX_W-1:0];
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // S_DONE reloads the output register itself
            if (r_out_valid && m_tready && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_cmd    <= w_in_cmd;
                        r_key    <= w_in_key;
                        r_data   <= w_in_data;
                        r_lo     <= '0;
                        r_hi     <= r_count;
                        r_found  <= '0;
                        if (w_in_cmd == CMD_INSERT && r_count == CNT_W'(TABLE_DEPTH)) begin
                            r_status <= ST_FULL;
                            r_state  <= S_DONE;
                        end else if (w_in_cmd == CMD_LOOKUP || w_in_cmd == CMD_INSERT ||
                                     w_in_cmd == CMD_DELETE) begin
                            r_status <= ST_OK;
                            r_state  <= S_SRCH_RD;
                        end else begin
                            r_status <= ST_OK;
                            r_state  <= S_DONE;
                        end
                    end
                end
                S_SRCH_RD: begin
                    if (r_lo < r_hi) begin
                        r_mid   <= w_mid;
                        r_state <= S_SRCH_CMP;
                    end else if (r_cmd == CMD_INSERT) begin
                        r_i     <= r_count;
                        r_state <= S_INS_RD;
                    end else begin
                        r_state <= S_CHK_RD;
                    end
                end
                S_SRCH_CMP: begin
                    if (w_go_right) begin
                        r_lo <= r_mid + CNT_W'(1);
                    end else begin
                        r_hi <= r_mid;
                    end
                    r_state <= S_SRCH_RD;
                end
                S_CHK_RD: begin
                    if (r_lo < r_count) begin
                        r_state <= S_CHK_CMP;
                    end else begin
                        r_status <= ST_MISS;
                        r_state  <= S_DONE;
                    end
                end
                S_CHK_CMP: begin
                    if (!w_key_eq) begin
                        r_status <= ST_MISS;
                        r_state  <= S_DONE;
                    end else if (r_cmd == CMD_LOOKUP) begin
                        r_found <= ram_rdata[DATA_W-1:0];
                        r_state <= S_DONE;
                    end else begin
                        r_i     <= r_lo;
                        r_state <= S_DEL_RD;
                    end
                end
                S_INS_RD: begin
                    if (r_i > r_lo) begin
                        r_state <= S_INS_WR;
                    end else begin
                        r_count <= r_count + CNT_W'(1);
                        r_state <= S_DONE;
                    end
                end
                S_INS_WR: begin
                    r_i     <= w_i_dec;
                    r_state <= S_INS_RD;
                end
                S_DEL_RD: begin
                    if (w_i_inc < r_count) begin
                        r_state <= S_DEL_WR;
                    end else begin
                        r_count <= r_count - CNT_W'(1);
                        r_state <= S_DONE;
                    end
                end
                S_DEL_WR: begin
                    r_i     <= w_i_inc;
                    r_state <= S_DEL_RD;
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= {6'(r_count), r_found[15:0], r_found[23:16],
                                        r_found[39:24], r_found[55:40], r_status};
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = r_out_data;

endmodule

// ===== test/sorted_key_table_top_tb.sv =====
// Testbench for the sorted key table: directed rows, then randomized command streams.
module sorted_key_table_top_tb;
    import sktab_pkg::*;

    // command code that the table ignores
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // command mixes of the random part
    localparam int MIX_FILL     = 0;
    localparam int MIX_BALANCED = 1;
    localparam int MIX_DRAIN    = 2;

    // idling modes of the random part
    localparam int IDLE_NONE     = 0;
    localparam int IDLE_SENDER   = 1;
    localparam int IDLE_RECEIVER = 2;
    localparam int IDLE_BOTH     = 3;

    localparam int NUM_PHASES     = 8;
    localparam int ITEMS_PER_PHASE = 80;
    localparam int N_DIRECTED     = 21;
    localparam int POOL_SIZE      = 12;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [63:0] key;
        logic [15:0] value;
        logic [15:0] modifier;
        logic [7:0]  format;
        logic [15:0] flags;
    } command_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [15:0]      value;
        logic [15:0]      modifier;
        logic [7:0]       format;
        logic [15:0]      flags;
        logic [CNT_W-1:0] count;
    } result_t;

    typedef struct packed {
        logic [15:0] value;
        logic [15:0] modifier;
        logic [7:0]  format;
        logic [15:0] flags;
    } entry_t;

    typedef struct packed {
        command_t cmd;
        logic     typed;
        result_t  want;
    } directed_row_t;

    localparam logic [63:0] KEY_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] KEY_MOV  = 64'h4D4F_5600_0000_0000;
    localparam logic [63:0] KEY_A    = 64'h4100_0000_0000_0000;
    localparam logic [63:0] KEY_A0B  = 64'h4100_4200_0000_0000;
    localparam logic [63:0] KEY_ADD  = 64'h4144_4400_0000_0000;
    localparam logic [63:0] KEY_ADDR = 64'h4144_4452_0000_0000;

    localparam logic [63:0] KEY_POOL [POOL_SIZE] = '{
        64'h0, KEY_ONES, KEY_MOV, KEY_A, KEY_A0B, KEY_ADD, KEY_ADDR,
        64'h4D4F_5642_0000_0000,   // MOVB
        64'h4A4D_5000_0000_0000,   // JMP
        64'h4200_0000_0000_0000,   // B
        64'h4C4F_4E47_4E41_4D45,   // LONGNAME
        64'h5A5A_5A5A_5A5A_5A5A
    };

    localparam directed_row_t DIRECTED_ROWS [N_DIRECTED] = '{
        // empty table
        '{'{CMD_LOOKUP, 64'h0, 16'h0, 16'h0, 8'h0, 16'h0}, 1'b1,
          '{ST_MISS, 16'h0, 16'h0, 8'h0, 16'h0, 6'd0}},
        '{'{CMD_DELETE, KEY_MOV, 16'h0, 16'h0, 8'h0, 16'h0}, 1'b1,
          '{ST_MISS, 16'h0, 16'h0, 8'h0, 16'h0, 6'd0}},
        // extremes of key and data
        '{'{CMD_INSERT, KEY_ONES, 16'hFFFF, 16'hFFFF, 8'hFF, 16'hFFFF}, 1'b1,
          '{ST_OK, 16'h0, 16'h0, 8'h0, 16'h0, 6'd1}},
        '{'{CMD_LOOKUP, KEY_ONES, 16'h0, 16'h0, 8'h0, 16'h0}, 1'b1,
          '{ST_OK, 16'hFFFF, 16'hFFFF, 8'hFF, 16'hFFFF, 6'd1}},
        '{'{CMD_INSERT, 64'h0, 16'h0, 16'h0, 8'h0, 16'h0}, 1'b1,
          '{ST_OK, 16'h0, 16'h0, 8'h0, 16'h0, 6'd2}},
        '{'{CMD_LOOKUP, 64'h0, 16'hFFFF, 16'hFFFF, 8'hFF, 16'hFFFF}, 1'b1,
          '{ST_OK, 16'h0, 16'h0, 8'h0, 16'h0, 6'd2}},
        // duplicate keys: lookup and delete take the older one
        '{'{CMD_INSERT, KEY_MOV, 16'h1234, 16'h5678, 8'h9A, 16'hBCDE}, 1'b0, '0},
        '{'{CMD_INSERT, KEY_MOV, 16'h1111, 16'h2222, 8'h33, 16'h4444}, 1'b0, '0},
        '{'{CMD_LOOKUP, KEY_MOV, 16'h0, 16'h0, 8'h0, 16'h0}, 1'b0, '0},
        '{'{CMD_DELETE, KEY_MOV, 16'h0, 16'h0, 8'h0, 16'h0}, 1'b0, '0},
        '{'{CMD_LOOKUP, KEY_MOV, 16'h0, 16'h0, 8'h0, 16'h0}, 1'b0, '0},
        // zero byte inside a key, bytes after it still count
        '{'{CMD_INSERT, KEY_A0B, 16'hA5A5, 16'h5A5A, 8'hC3, 16'h3C3C}, 1'b0, '0},
        '{'{CMD_LOOKUP, KEY_A, 16'h0, 16'h0, 8'h0, 16'h0}, 1'b0, '0},
        '{'{CMD_LOOKUP, KEY_A0B, 16'h0, 16'h0, 8'h0, 16'h0}, 1'b0, '0},
        '{'{CMD_UNUSED, KEY_MOV, 16'hDEAD, 16'hBEEF, 8'h5A, 16'hA5A5}, 1'b0, '0},
        '{'{CMD_DELETE, KEY_ONES, 16'h0, 16'h0, 8'h0, 16'h0}, 1'b0, '0},
        '{'{CMD_LOOKUP, KEY_ONES, 16'h0, 16'h0, 8'h0, 16'h0}, 1'b0, '0},
        '{'{CMD_DELETE, 64'h0, 16'h0, 16'h0, 8'h0, 16'h0}, 1'b0, '0},
        '{'{CMD_INSERT, KEY_ADD, 16'h0001, 16'h8000, 8'h01, 16'h8000}, 1'b0, '0},
        '{'{CMD_LOOKUP, KEY_ADD, 16'h7E7E, 16'h8181, 8'h42, 16'h2424}, 1'b0, '0},
        '{'{CMD_DELETE, KEY_ADDR, 16'h0, 16'h0, 8'h0, 16'h0}, 1'b0, '0}
    };

    logic                 i_clk    = 1'b0;
    logic                 i_rst_n  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    // command, key, op_value, op_modifier, op_format, cpu_flags, zero fill
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    // status, found_value, found_modifier, found_format, found_cpu_flags, entry_count
    logic [M_TDATA_W-1:0] m_tdata;

    // shadow copy of the table
    logic [63:0] table_keys [TABLE_DEPTH];
    entry_t      table_data [TABLE_DEPTH];
    int          table_used = 0;

    result_t pending_results [$];
    int      fail_count      = 0;
    int      send_idle_pct   = 0;
    int      recv_stall_pct  = 0;
    int      holdoff_request = 0;

    sorted_key_table_top u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // first slot whose key is not below k
    function automatic int first_not_below(logic [63:0] k);
        int pos;
        pos = 0;
        while (pos < table_used && table_keys[pos] < k) pos++;
        return pos;
    endfunction

    function automatic result_t apply_command(command_t c);
        result_t     r;
        logic [63:0] k;
        int          pos;
        r = '0;
        k = c.key & KEY_MASK;
        case (c.cmd)
            CMD_LOOKUP: begin
                pos = first_not_below(k);
                if (pos < table_used && table_keys[pos] == k) begin
                    r.value    = table_data[pos].value;
                    r.modifier = table_data[pos].modifier;
                    r.format   = table_data[pos].format;
                    r.flags    = table_data[pos].flags;
                end else begin
                    r.status = ST_MISS;
                end
            end
            CMD_INSERT: begin
                if (table_used >= TABLE_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    // new entry goes behind all equal keys
                    pos = 0;
                    while (pos < table_used && table_keys[pos] <= k) pos++;
                    for (int i = table_used; i > pos; i--) begin
                        table_keys[i] = table_keys[i-1];
                        table_data[i] = table_data[i-1];
                    end
                    table_keys[pos] = k;
                    table_data[pos] = '{c.value, c.modifier, c.format, c.flags};
                    table_used++;
                end
            end
            CMD_DELETE: begin
                pos = first_not_below(k);
                if (pos < table_used && table_keys[pos] == k) begin
                    for (int i = pos; i + 1 < table_used; i++) begin
                        table_keys[i] = table_keys[i+1];
                        table_data[i] = table_data[i+1];
                    end
                    table_used--;
                end else begin
                    r.status = ST_MISS;
                end
            end
            default: ;
        endcase
        r.count = table_used[CNT_W-1:0];
        return r;
    endfunction

    // called at a rising edge; returns at the edge that takes the transaction
    task automatic send_command(command_t c, logic typed, result_t want);
        int      gap;
        result_t predicted;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct && gap < 200) gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, c.flags, c.format, c.modifier, c.value, c.key, c.cmd};
        do @(posedge i_clk); while (s_tready !== 1'b1);
        predicted = apply_command(c);
        pending_results.push_back(typed ? want : predicted);
    endtask

    function automatic logic [63:0] pick_key(logic want_stored);
        logic [63:0] k;
        if (want_stored && table_used != 0)
            return table_keys[$urandom_range(table_used - 1)];
        case ($urandom_range(9))
            0, 1: k = {$urandom, $urandom};
            2: begin
                // pool key with a random tail
                k = KEY_POOL[$urandom_range(POOL_SIZE - 1)];
                k[23:0] = 24'($urandom);
            end
            default: k = KEY_POOL[$urandom_range(POOL_SIZE - 1)];
        endcase
        return k;
    endfunction

    function automatic command_t make_command(int mix);
        command_t c;
        int       roll;
        int       ins_pct;
        int       look_pct;
        int       del_pct;
        logic [31:0] r0;
        logic [31:0] r1;
        case (mix)
            MIX_FILL:     begin ins_pct = 80; look_pct = 12; del_pct = 5;  end
            MIX_BALANCED: begin ins_pct = 35; look_pct = 35; del_pct = 27; end
            MIX_DRAIN:    begin ins_pct = 18; look_pct = 22; del_pct = 57; end
            default:      $fatal(1, "unknown command mix %0d", mix);
        endcase
        roll = $urandom_range(99);
        if (roll < ins_pct)                          c.cmd = CMD_INSERT;
        else if (roll < ins_pct + look_pct)          c.cmd = CMD_LOOKUP;
        else if (roll < ins_pct + look_pct + del_pct) c.cmd = CMD_DELETE;
        else                                         c.cmd = CMD_UNUSED;
        c.key = pick_key(c.cmd != CMD_INSERT ? ($urandom_range(99) < 60)
                                             : ($urandom_range(99) < 25));
        r0 = $urandom;
        r1 = $urandom;
        c.value    = r0[15:0];
        c.modifier = r0[31:16];
        c.format   = r1[7:0];
        c.flags    = r1[23:8];
        return c;
    endfunction

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected %h, got %h", name, want, got);
            fail_count++;
        end
    endtask

    // result side: random backpressure plus requested long hold-offs
    initial begin : result_side
        int      hold_left;
        result_t want;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (m_tvalid === 1'b1 && m_tready) begin
                if (pending_results.size() == 0) begin
                    $error("result transaction with nothing expected: %h", m_tdata);
                    fail_count++;
                end else begin
                    want = pending_results.pop_front();
                    check_field("status",          want.status,   m_tdata[1:0]);
                    check_field("found_value",     want.value,    m_tdata[17:2]);
                    check_field("found_modifier",  want.modifier, m_tdata[33:18]);
                    check_field("found_format",    want.format,   m_tdata[41:34]);
                    check_field("found_cpu_flags", want.flags,    m_tdata[57:42]);
                    check_field("entry_count",     want.count,    m_tdata[63:58]);
                end
            end
            if (holdoff_request > 0) begin
                hold_left = holdoff_request;
                holdoff_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    initial begin : command_side
        command_t c;
        int       idle_mode;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIRECTED_ROWS[i])
            send_command(DIRECTED_ROWS[i].cmd, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            idle_mode = ph % 4;
            case (idle_mode)
                IDLE_NONE:     begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                IDLE_SENDER:   begin send_idle_pct = 84; recv_stall_pct = 0;  end
                IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 84; end
                IDLE_BOTH:     begin send_idle_pct = 25; recv_stall_pct = 25; end
                default:       $fatal(1, "unknown idling mode %0d", idle_mode);
            endcase
            if (ph == 3) begin
                // let all outstanding results drain before going on
                s_tvalid <= 1'b0;
                @(posedge i_clk);
                while (pending_results.size() != 0) @(posedge i_clk);
            end
            if (ph == 4)
                holdoff_request = 400;  // back up the pipe so s_tready drops
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                c = make_command(ph % 3);
                send_command(c, 1'b0, '0);
            end
        end
        s_tvalid <= 1'b0;
        recv_stall_pct = 0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial begin : watchdog
        #2000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
